>>> rtl/assert_macros.svh
// assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define ASSERT_IMP(label, clk, rst_n, a, c, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, a, c, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

>>> rtl/mlfq_pkg.sv
// ----------------------------------------------------------------------------
// mlfq_pkg
// shared types and constants of the feedback queue scheduler
// ----------------------------------------------------------------------------
package mlfq_pkg;
    localparam int SLOTS = 32;
    localparam int SW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam int SUMW = 32 + CW;

    localparam logic [1:0] FN_ADMIT = 2'd0;
    localparam logic [1:0] FN_START = 2'd1;
    localparam logic [1:0] FN_REPORT = 2'd2;
    localparam logic [1:0] FN_RELEASE = 2'd3;

    localparam logic [2:0] ST_ADMITTED = 3'd0;
    localparam logic [2:0] ST_NOSLOT = 3'd1;
    localparam logic [2:0] ST_DISPATCH = 3'd2;
    localparam logic [2:0] ST_ROUND_END = 3'd3;
    localparam logic [2:0] ST_RELEASED = 3'd4;
    localparam logic [2:0] ST_OVERFLOW = 3'd5;

    localparam logic [1:0] DST_HIGH = 2'd0;
    localparam logic [1:0] DST_MID = 2'd1;
    localparam logic [1:0] DST_LOW = 2'd2;
    localparam logic [1:0] DST_DROP = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture request, start search step
        logic search;    // one search step
        logic exec;      // apply request
        logic div_step;  // one divider step
        logic finish;    // store average, rotate level
        logic rd_head;   // read memory at head of level
        logic emit;      // load result register
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic search_done;
        logic need_div;
        logic div_done;
    } stat_t;
endpackage

>>> rtl/multilevel_feedback_queue_scheduler_unit.sv
// ----------------------------------------------------------------------------
// multilevel_feedback_queue_scheduler_unit
// three-level feedback scheduler over process slots
// ----------------------------------------------------------------------------
// channel   dir  tdata (low bit up)                          tuser
// s_axis    in   func[1:0] slot[6:2] still_running[7]        -
//                wait_time[39:8]
// m_axis    out  status[2:0] out_slot[7:3] destination[9:8]  -
//                level[11:10]
// cfg       in   cfg_we, cfg_index, cfg_data[7:0]
//
// one request at a time; when a round ends, a serial divider steps over the
// 38-bit sum and then stores the average, and on admit the slot search
// steps over up to 32 slots.
// reset clears control state; queue memory holds garbage until written.
// a result waits in the output register while the next request is taken.
module multilevel_feedback_queue_scheduler_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // func, slot, still_running, wait_time
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // status, out_slot, destination, level
);
    mlfq_pkg::cmd_t cmd;
    mlfq_pkg::stat_t stat;
    logic [2:0] r_status;
    logic [4:0] r_slot;
    logic [1:0] r_dest, r_level;
    logic ovalid_reg;
    logic out_free;

    assign out_free = !ovalid_reg || m_axis_tready;

    mlfq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .out_free (out_free),
        .stat     (stat),
        .cmd      (cmd)
    );

    mlfq_dpath u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .func          (s_axis_tdata[1:0]),
        .slot          (s_axis_tdata[6:2]),
        .still_running (s_axis_tdata[7]),
        .wait_time     (s_axis_tdata[39:8]),
        .cmd           (cmd),
        .stat          (stat),
        .r_status      (r_status),
        .r_slot        (r_slot),
        .r_dest        (r_dest),
        .r_level       (r_level)
    );

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ovalid_reg <= 1'b0;
        else if (cmd.emit)
            ovalid_reg <= 1'b1;
        else if (m_axis_tready)
            ovalid_reg <= 1'b0;
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata = {4'd0, r_level, r_dest, r_slot, r_status};
endmodule

>>> rtl/mlfq_ctrl.sv
// ----------------------------------------------------------------------------
// mlfq_ctrl
// sequencer of one request: search, execute, divide, head read, result
// ----------------------------------------------------------------------------
module mlfq_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic            out_free,
    input  mlfq_pkg::stat_t stat,
    output mlfq_pkg::cmd_t  cmd
);
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SRCH = 6'b000010,
        S_EXEC = 6'b000100,
        S_DIV  = 6'b001000,
        S_HEAD = 6'b010000,
        S_EMIT = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = S_SRCH;
                end
            end
            S_SRCH:
            begin
                cmd.search = 1'b1;
                if (stat.search_done)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                state_next = stat.need_div ? S_DIV : S_HEAD;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_done)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_HEAD;
                end
            end
            S_HEAD:
            begin
                cmd.rd_head = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    cmd.emit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end
endmodule

>>> rtl/mlfq_dpath.sv
// ----------------------------------------------------------------------------
// mlfq_dpath
// slot map, queue rings, round bookkeeping and serial divider
// ----------------------------------------------------------------------------
module mlfq_dpath (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [7:0]          cfg_data,
    input  logic [1:0]          func,
    input  logic [4:0]          slot,
    input  logic                still_running,
    input  logic [31:0]         wait_time,
    input  mlfq_pkg::cmd_t      cmd,
    output mlfq_pkg::stat_t     stat,
    output logic [2:0]          r_status,
    output logic [4:0]          r_slot,
    output logic [1:0]          r_dest,
    output logic [1:0]          r_level
);
    localparam int SW = mlfq_pkg::SW;
    localparam int CW = mlfq_pkg::CW;
    localparam int SUMW = mlfq_pkg::SUMW;
    localparam logic [CW-1:0] FULL = CW'(mlfq_pkg::SLOTS);
    localparam logic [SW-1:0] LAST = SW'(mlfq_pkg::SLOTS - 1);

    logic [7:0] alpha_reg, beta_reg;
    logic [mlfq_pkg::SLOTS-1:0] map_reg;
    logic [SW-1:0] spos_reg;
    logic [SW-1:0] head_reg [3];
    logic [SW-1:0] tail_reg [3];
    logic [CW-1:0] cnt_reg [3];
    logic [1:0] lvl_reg;
    logic [CW-1:0] rem_reg, disp_reg;
    logic [SUMW-1:0] sum_reg;
    logic [31:0] mid_avg_reg, low_avg_reg;

    // captured request
    logic [1:0] f_reg;
    logic [4:0] s_reg;
    logic run_reg;
    logic [31:0] w_reg;

    // search
    logic [SW-1:0] cand_reg;
    logic [CW-1:0] scnt_reg;
    logic found_reg;

    // divider
    logic [SUMW-1:0] quo_reg;
    logic [CW:0] rmd_reg;
    logic [5:0] dcnt_reg;

    // result
    logic [2:0] st_reg;
    logic [4:0] os_reg;
    logic [1:0] dst_reg;
    logic ovf_reg, rend_reg, hd_reg;

    // queue memory, read data registered
    logic [SW-1:0] mem [3*mlfq_pkg::SLOTS];
    logic [SW-1:0] rdata_reg;

    // demotion compare operands, registered product
    logic [39:0] prod_reg;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg <= 8'd16;
            beta_reg <= 8'd16;
        end
        else if (cfg_we)
        begin
            if (cfg_index)
                beta_reg <= cfg_data;
            else
                alpha_reg <= cfg_data;
        end
    end

    logic [SW-1:0] cand_next;
    assign cand_next = (cand_reg == LAST) ? '0 : cand_reg + 1'b1;
    assign stat.search_done = found_reg || (scnt_reg == FULL) || (f_reg != mlfq_pkg::FN_ADMIT);

    // decision in exec
    logic [1:0] dest;
    logic [1:0] cur;
    logic active;
    assign cur = lvl_reg;
    assign active = (rem_reg != '0);
    always_comb
    begin
        logic gt;
        gt = ({4'd0, w_reg, 4'd0} > prod_reg);
        if (!run_reg)
            dest = mlfq_pkg::DST_DROP;
        else if (cur == 2'd0)
            dest = gt ? mlfq_pkg::DST_MID : mlfq_pkg::DST_HIGH;
        else if (cur == 2'd1)
            dest = gt ? mlfq_pkg::DST_LOW : mlfq_pkg::DST_MID;
        else
            dest = mlfq_pkg::DST_LOW;
    end

    // target ring full; the current level has just lost its head
    logic dest_full;
    assign dest_full = (dest != mlfq_pkg::DST_DROP) && (dest != cur) && (cnt_reg[dest] == FULL);

    logic [CW-1:0] start_cnt;
    assign start_cnt = cnt_reg[cur];
    assign stat.need_div = (f_reg == mlfq_pkg::FN_START && !active && start_cnt == '0)
                         || (f_reg == mlfq_pkg::FN_REPORT && active && rem_reg == CW'(1));
    assign stat.div_done = (dcnt_reg == 6'(SUMW));

    logic [CW:0] trial;
    assign trial = {rmd_reg[CW-1:0], quo_reg[SUMW-1]} - {1'b0, disp_reg};

    logic [7:0] scale;
    logic [31:0] avg_sel;
    assign scale = (cur == 2'd0) ? alpha_reg : beta_reg;
    assign avg_sel = (cur == 2'd0) ? mid_avg_reg : low_avg_reg;

    function automatic logic [SW-1:0] inc(input logic [SW-1:0] v);
        inc = (v == LAST) ? '0 : v + 1'b1;
    endfunction

    // memory port
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            if (f_reg == mlfq_pkg::FN_ADMIT && found_reg && cnt_reg[0] != FULL)
                mem[{2'd0, tail_reg[0]}] <= cand_reg;
            else if (f_reg == mlfq_pkg::FN_REPORT && active && dest != mlfq_pkg::DST_DROP
                     && !dest_full)
                mem[7'(dest) * 7'(mlfq_pkg::SLOTS) + 7'(tail_reg[dest])] <= rdata_reg;
        end
        if (cmd.load || cmd.rd_head)
            rdata_reg <= mem[7'(lvl_reg) * 7'(mlfq_pkg::SLOTS) + 7'(head_reg[lvl_reg])];
    end

    // main state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_reg <= '0;
            spos_reg <= LAST;
            for (int i = 0; i < 3; i++)
            begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
                cnt_reg[i] <= '0;
            end
            lvl_reg <= '0;
            rem_reg <= '0;
            disp_reg <= '0;
            sum_reg <= '0;
            mid_avg_reg <= '0;
            low_avg_reg <= '0;
            found_reg <= 1'b0;
            scnt_reg <= '0;
            cand_reg <= '0;
            dcnt_reg <= '0;
            ovf_reg <= 1'b0;
            rend_reg <= 1'b0;
            hd_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                found_reg <= 1'b0;
                scnt_reg <= '0;
                cand_reg <= inc(spos_reg);
            end
            if (cmd.search && !stat.search_done)
            begin
                if (!map_reg[cand_reg])
                    found_reg <= 1'b1;
                else
                    cand_reg <= cand_next;
                scnt_reg <= scnt_reg + 1'b1;
            end
            if (cmd.exec)
            begin
                ovf_reg <= 1'b0;
                rend_reg <= 1'b0;
                hd_reg <= 1'b0;
                dcnt_reg <= '0;
                unique case (f_reg)
                    mlfq_pkg::FN_ADMIT:
                    begin
                        if (found_reg && cnt_reg[0] != FULL)
                        begin
                            tail_reg[0] <= inc(tail_reg[0]);
                            cnt_reg[0] <= cnt_reg[0] + 1'b1;
                            map_reg[cand_reg] <= 1'b1;
                            spos_reg <= cand_reg;
                        end
                        else if (found_reg)
                            ovf_reg <= 1'b1;
                    end
                    mlfq_pkg::FN_START:
                    begin
                        if (!active)
                        begin
                            rem_reg <= start_cnt;
                            disp_reg <= '0;
                            sum_reg <= '0;
                        end
                        if (!active && start_cnt == '0)
                            rend_reg <= 1'b1;
                        else
                            hd_reg <= 1'b1;
                    end
                    mlfq_pkg::FN_REPORT:
                    begin
                        if (active)
                        begin
                            head_reg[cur] <= inc(head_reg[cur]);
                            rem_reg <= rem_reg - 1'b1;
                            disp_reg <= disp_reg + 1'b1;
                            sum_reg <= sum_reg + SUMW'(w_reg);
                            if (dest != mlfq_pkg::DST_DROP)
                            begin
                                if (!dest_full)
                                begin
                                    tail_reg[dest] <= inc(tail_reg[dest]);
                                    cnt_reg[dest] <= cnt_reg[dest]
                                        + ((dest == cur) ? CW'(0) : CW'(1));
                                end
                                else
                                    ovf_reg <= 1'b1;
                            end
                            if (dest == mlfq_pkg::DST_DROP || dest_full || dest != cur)
                                cnt_reg[cur] <= cnt_reg[cur] - 1'b1;
                            if (rem_reg == CW'(1))
                                rend_reg <= 1'b1;
                            else
                                hd_reg <= 1'b1;
                        end
                        else
                            rend_reg <= 1'b1;
                    end
                    mlfq_pkg::FN_RELEASE:
                    begin
                        if (32'(s_reg) < 32'(mlfq_pkg::SLOTS))
                            map_reg[SW'(s_reg)] <= 1'b0;
                    end
                    default: ;
                endcase
            end
            if (cmd.div_step && !stat.div_done)
                dcnt_reg <= dcnt_reg + 1'b1;
            if (cmd.finish)
            begin
                if (lvl_reg == 2'd1)
                    mid_avg_reg <= (disp_reg == '0) ? '0 : quo_reg[31:0];
                else if (lvl_reg == 2'd2)
                    low_avg_reg <= (disp_reg == '0) ? '0 : quo_reg[31:0];
                lvl_reg <= (lvl_reg == 2'd2) ? 2'd0 : lvl_reg + 1'b1;
                rem_reg <= '0;
            end
        end
    end

    // request capture, product, divider datapath
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            f_reg <= func;
            s_reg <= slot;
            run_reg <= still_running;
            w_reg <= wait_time;
        end
        if (cmd.search)
            prod_reg <= 40'(scale) * 40'(avg_sel);
        if (cmd.exec)
        begin
            quo_reg <= sum_reg + ((f_reg == mlfq_pkg::FN_REPORT) ? SUMW'(w_reg) : '0);
            rmd_reg <= '0;
        end
        else if (cmd.div_step && !stat.div_done)
        begin
            if (!trial[CW])
            begin
                rmd_reg <= trial;
                quo_reg <= {quo_reg[SUMW-2:0], 1'b1};
            end
            else
            begin
                rmd_reg <= {rmd_reg[CW-1:0], quo_reg[SUMW-1]};
                quo_reg <= {quo_reg[SUMW-2:0], 1'b0};
            end
        end
    end

    // result; the head is read in the head state, before the emit
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            unique case (f_reg)
                mlfq_pkg::FN_ADMIT:
                begin
                    st_reg <= !found_reg ? mlfq_pkg::ST_NOSLOT
                            : (cnt_reg[0] == FULL ? mlfq_pkg::ST_OVERFLOW
                                                  : mlfq_pkg::ST_ADMITTED);
                    os_reg <= found_reg ? 5'(cand_reg) : 5'd0;
                    dst_reg <= mlfq_pkg::DST_HIGH;
                end
                mlfq_pkg::FN_START:
                begin
                    st_reg <= mlfq_pkg::ST_DISPATCH;
                    os_reg <= '0;
                    dst_reg <= mlfq_pkg::DST_HIGH;
                end
                mlfq_pkg::FN_REPORT:
                begin
                    st_reg <= mlfq_pkg::ST_DISPATCH;
                    os_reg <= 5'(rdata_reg);
                    dst_reg <= active ? dest : mlfq_pkg::DST_DROP;
                end
                mlfq_pkg::FN_RELEASE:
                begin
                    st_reg <= mlfq_pkg::ST_RELEASED;
                    os_reg <= s_reg;
                    dst_reg <= mlfq_pkg::DST_HIGH;
                end
                default: ;
            endcase
        end
        if (cmd.emit)
        begin
            if (ovf_reg)
                r_status <= mlfq_pkg::ST_OVERFLOW;
            else if (rend_reg)
                r_status <= mlfq_pkg::ST_ROUND_END;
            else
                r_status <= st_reg;
            if (ovf_reg)
                r_slot <= os_reg;
            else if (rend_reg)
                r_slot <= '0;
            else if (hd_reg)
                r_slot <= 5'(rdata_reg);
            else
                r_slot <= os_reg;
            r_dest <= dst_reg;
            r_level <= lvl_reg;
        end
    end
endmodule

>>> rtl/mlfq_checker.sv
// ----------------------------------------------------------------------------
// mlfq_checker
// port-level checks of the scheduler
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module mlfq_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);
    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "ready held after accept")
    `ASSERT_IMP(a_status_range, clk, rst_n, m_axis_tvalid, m_axis_tdata[2:0] <= 3'd5, "bad status")
    `ASSERT_IMP(a_level_range, clk, rst_n, m_axis_tvalid, m_axis_tdata[11:10] != 2'd3, "bad level")
    `ASSERT_NEXT(a_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "output dropped")
endmodule

bind multilevel_feedback_queue_scheduler_unit mlfq_checker u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
